/* rtl/core/trtp_pkg.sv */
// ----------------------------------------------------------------------------
// trtp_pkg
// shared types and constants of the tga rle tile packer
// ----------------------------------------------------------------------------
`default_nettype none

package trtp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned NIBBLE_W    = 4;
	localparam int unsigned TILE_EDGE   = 16;
	localparam int unsigned ROW_BITS_W  = TILE_EDGE * NIBBLE_W;
	localparam int unsigned PAIR_W      = 16;
	localparam int unsigned HDR_RUN_BIT = 7;
	localparam int unsigned HDR_CNT_W   = 7;
	localparam int unsigned PIX_MAX     = 15;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned TILES_W    = 7;
	localparam int unsigned HEIGHT_W   = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN     = 2'd3;

	typedef struct packed {
		logic push;
		logic use_run;
		logic load_run;
	} trtp_cmd_t;

	typedef struct packed {
		logic group_full;
		logic image_end;
		logic out_free;
	} trtp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/trtp_ctrl.sv */
// ----------------------------------------------------------------------------
// trtp_ctrl
// packet decoder and run sequencer, issues one pixel push per cycle unless the output register is held
// ----------------------------------------------------------------------------
`default_nettype none

module trtp_ctrl
	import trtp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rle_mode,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire trtp_sts_t         sts,
	output trtp_cmd_t              cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                 state_q, state_n;
	logic [BYTE_W-1:0]    repeat_q, repeat_n;
	logic                 expect_q, expect_n;
	logic [HDR_CNT_W-1:0] remain_q, remain_n;
	logic                 accept;

	assign in_ready = (state_q == ST_IDLE) && (sts.out_free || !sts.group_full);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_n  = state_q;
		repeat_n = repeat_q;
		expect_n = expect_q;
		remain_n = remain_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!rle_mode) begin
						cmd.push = 1'b1;
					end else if (expect_q) begin
						expect_n     = 1'b0;
						cmd.load_run = 1'b1;
						cmd.push     = 1'b1;
						if (repeat_q[HDR_RUN_BIT]) begin
							repeat_n = '0;
							remain_n = repeat_q[HDR_CNT_W-1:0];
							if ((repeat_q[HDR_CNT_W-1:0] != '0) && !sts.image_end) begin
								state_n = ST_RUN;
							end
						end else begin
							repeat_n = {1'b0, repeat_q[HDR_CNT_W-1:0]};
						end
					end else if (repeat_q != '0) begin
						repeat_n = repeat_q - BYTE_W'(1);
						cmd.push = 1'b1;
					end else begin
						repeat_n = data_byte;
						expect_n = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (sts.out_free || !sts.group_full) begin
					cmd.push    = 1'b1;
					cmd.use_run = 1'b1;
					remain_n    = remain_q - HDR_CNT_W'(1);
					if ((remain_q == HDR_CNT_W'(1)) || sts.image_end) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
		if (cmd.push && sts.image_end) begin
			repeat_n = '0;
			expect_n = 1'b0;
			state_n  = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			repeat_q <= '0;
			expect_q <= 1'b0;
			remain_q <= '0;
		end else begin
			state_q  <= state_n;
			repeat_q <= repeat_n;
			expect_q <= expect_n;
			remain_q <= remain_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/trtp_dp.sv */
// ----------------------------------------------------------------------------
// trtp_dp
// pixel packing shift register, row and column counters, output register
// ----------------------------------------------------------------------------
`default_nettype none

module trtp_dp
	import trtp_pkg::*;
#(
	parameter int MAX_TILES_ACROSS = 64,
	parameter int MAX_HEIGHT       = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire trtp_cmd_t             cmd,
	input  wire logic [BYTE_W-1:0]     data_byte,
	input  wire logic [TILES_W-1:0]    tiles_across,
	input  wire logic [HEIGHT_W-1:0]   image_height,
	input  wire logic                  top_down,
	output trtp_sts_t                  sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ROW_BITS_W-1:0]      row_bits,
	output logic [PAIR_W-1:0]          pair_index,
	output logic                       last_word
);

	localparam int COL_W = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
	localparam int ET_W  = $clog2(MAX_TILES_ACROSS + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
	localparam int PIG_W = $clog2(TILE_EDGE);

	logic [BYTE_W-1:0]     run_value_q;
	logic [ROW_BITS_W-1:0] packed_q;
	logic [PIG_W-1:0]      pig_q;
	logic [COL_W-1:0]      group_q;
	logic [ROW_W-1:0]      rows_q;

	logic [ET_W-1:0]       eff_tiles;
	logic [EH_W-1:0]       eff_height;
	logic [EH_W-1:0]       height_m1;
	logic [ROW_W-1:0]      row;
	logic [COL_W-1:0]      col;
	logic [ROW_W-1:0]      cur_row;
	logic                  last_col;
	logic                  last_row;
	logic [31:0]           pair_sum;
	logic [BYTE_W-1:0]     src;
	logic [NIBBLE_W-1:0]   pix;
	logic [ROW_BITS_W-1:0] shifted;

	always_comb begin
		if (tiles_across == '0) begin
			eff_tiles = ET_W'(1);
		end else if (32'(tiles_across) > 32'(MAX_TILES_ACROSS)) begin
			eff_tiles = ET_W'(MAX_TILES_ACROSS);
		end else begin
			eff_tiles = ET_W'(tiles_across);
		end
		if (image_height == '0) begin
			eff_height = EH_W'(1);
		end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
			eff_height = EH_W'(MAX_HEIGHT);
		end else begin
			eff_height = EH_W'(image_height);
		end
	end

	assign height_m1 = eff_height - EH_W'(1);

	always_comb begin
		if (32'(rows_q) >= 32'(eff_height)) begin
			row = ROW_W'(height_m1);
		end else begin
			row = rows_q;
		end
		if (32'(group_q) >= 32'(eff_tiles)) begin
			col = COL_W'(eff_tiles - ET_W'(1));
		end else begin
			col = group_q;
		end
	end

	assign last_col = (32'(col) == (32'(eff_tiles) - 32'd1));
	assign last_row = (32'(row) == 32'(height_m1));
	assign cur_row  = top_down ? row : ROW_W'(height_m1 - EH_W'(row));
	assign pair_sum = 32'(cur_row[3:0])
		+ ((32'(cur_row >> 4) * 32'(eff_tiles) + 32'(col)) << 4);

	assign src     = cmd.use_run ? run_value_q : data_byte;
	assign pix     = (src > BYTE_W'(PIX_MAX)) ? '0 : src[NIBBLE_W-1:0];
	assign shifted = {pix, packed_q[ROW_BITS_W-1:NIBBLE_W]};

	assign sts.group_full = (pig_q == PIG_W'(TILE_EDGE - 1));
	assign sts.image_end  = sts.group_full && last_col && last_row;
	assign sts.out_free   = !out_valid || out_ready;

	// packing and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			packed_q    <= '0;
			pig_q       <= '0;
			group_q     <= '0;
			rows_q      <= '0;
		end else begin
			if (cmd.load_run) begin
				run_value_q <= data_byte;
			end
			if (cmd.push) begin
				packed_q <= shifted;
				if (sts.group_full) begin
					pig_q <= '0;
					if (last_col) begin
						group_q <= '0;
						if (last_row) begin
							run_value_q <= '0;
							packed_q    <= '0;
							rows_q      <= '0;
						end else begin
							rows_q <= row + ROW_W'(1);
						end
					end else begin
						group_q <= col + COL_W'(1);
					end
				end else begin
					pig_q <= pig_q + PIG_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push && sts.group_full) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && sts.group_full) begin
			row_bits   <= shifted;
			pair_index <= pair_sum[PAIR_W-1:0];
			last_word  <= last_col && last_row;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tga_rle_tile_packer.sv */
// ----------------------------------------------------------------------------
// tga_rle_tile_packer
// 8-bit indexed tga pixel stream to 64-bit 4-bit-per-pixel tile rows
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready, data_byte) takes one pixel data byte per
//   transfer; out channel (out_valid/out_ready) gives row_bits, pair_index
//   and last_word; cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes rle_mode, tiles_across, image_height and top_down, always ready.
//   raw pixels, headers and literal bytes: one byte per cycle while in_ready is high.
//   a run packet of n pixels takes its value byte with the first pixel, and
//   in_ready stays low while the remaining n-1 are pushed (or until the
//   image ends), since the packing shift register adds one pixel per push.
//   a row word is registered and valid the cycle after its sixteenth pixel.
//   a single output register holds the word; while it is full and not taken,
//   only the pixel that would complete the next word waits.
//   reset loads the register defaults (raw mode, 4 tiles, 16 rows, top-down)
//   and starts a fresh image; after the last word the block starts over.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_tile_packer
	import trtp_pkg::*;
#(
	parameter int MAX_TILES_ACROSS = 64,
	parameter int MAX_HEIGHT       = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [BYTE_W-1:0]     data_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ROW_BITS_W-1:0]      row_bits,
	output logic [PAIR_W-1:0]          pair_index,
	output logic                       last_word,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic                rle_mode_q;
	logic [TILES_W-1:0]  tiles_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                top_down_q;
	trtp_cmd_t           cmd;
	trtp_sts_t           sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_mode_q <= 1'b0;
			tiles_q    <= TILES_W'(4);
			height_q   <= HEIGHT_W'(16);
			top_down_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RLE_MODE:     rle_mode_q <= cfg_data[0];
				CFG_TILES_ACROSS: tiles_q    <= cfg_data[TILES_W-1:0];
				CFG_IMAGE_HEIGHT: height_q   <= cfg_data[HEIGHT_W-1:0];
				CFG_TOP_DOWN:     top_down_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	trtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rle_mode  (rle_mode_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.sts       (sts),
		.cmd       (cmd)
	);

	trtp_dp #(
		.MAX_TILES_ACROSS (MAX_TILES_ACROSS),
		.MAX_HEIGHT       (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.tiles_across (tiles_q),
		.image_height (height_q),
		.top_down     (top_down_q),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_bits     (row_bits),
		.pair_index   (pair_index),
		.last_word    (last_word)
	);

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && sts.group_full |-> sts.out_free)
		else $error("row word completed while output register is held");

	a_end_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && sts.image_end |=> out_valid && last_word)
		else $error("image end did not emit a last word");

	a_raw_push: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !rle_mode_q |-> cmd.push && !cmd.use_run)
		else $error("raw byte transfer without a pixel push");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the tga rle tile packer against a cycle-free predictor of its rows
// ----------------------------------------------------------------------------
// pixel bytes go in over the in channel. Raw bytes, run packets and literal
// packets are sent in bursts with random gaps. The out channel stalls on a
// pattern of its own, and once holds off long enough to back up the block.
// The register set is changed between phases, out-of-range values and
// mid-image changes included. Every row word is compared field by field.
// ----------------------------------------------------------------------------

module testbench;
	import trtp_pkg::*;

	localparam int MAX_TILES    = 64;
	localparam int MAX_ROWS     = 1024;
	localparam int DRAIN_CYCLES = 160;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 20;
	localparam logic [BYTE_W-1:0] RUN_FLAG = BYTE_W'(1 << HDR_RUN_BIT);

	typedef struct packed {
		logic [ROW_BITS_W-1:0] pixels;
		logic [PAIR_W-1:0]     pair;
		logic                  last;
	} row_word_t;

	class tile_row_board;
		bit                   rle_on;
		bit [TILES_W-1:0]     tiles_reg;
		bit [HEIGHT_W-1:0]    height_reg;
		bit                   top_first;
		bit [BYTE_W-1:0]      pkt_count;
		bit                   want_value;
		bit [ROW_BITS_W-1:0]  shift_row;
		int unsigned          pix_cnt;
		int unsigned          col_cnt;
		int unsigned          rows_cnt;
		row_word_t            pending[$];
		int unsigned          errors;
		int unsigned          words_seen;
		int unsigned          image_ends;

		function void clear_image();
			pkt_count  = 0;
			want_value = 0;
			shift_row  = 0;
			pix_cnt    = 0;
			col_cnt    = 0;
			rows_cnt   = 0;
		endfunction

		function void reset_all();
			rle_on     = 0;
			tiles_reg  = 4;
			height_reg = 16;
			top_first  = 1;
			clear_image();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_RLE_MODE:     rle_on     = data[0];
				CFG_TILES_ACROSS: tiles_reg  = data[TILES_W-1:0];
				CFG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
				CFG_TOP_DOWN:     top_first  = data[0];
				default: ;
			endcase
		endfunction

		// returns 1 when the image closed and the state went back to reset
		function bit add_pixel(logic [BYTE_W-1:0] b);
			logic [NIBBLE_W-1:0] v;
			int unsigned tiles, height, row, col, cur;
			bit last_col, last_row;
			row_word_t w;
			v = (b > PIX_MAX) ? '0 : b[NIBBLE_W-1:0];
			shift_row = {v, shift_row[ROW_BITS_W-1:NIBBLE_W]};
			pix_cnt++;
			if (pix_cnt < TILE_EDGE) return 0;
			pix_cnt = 0;
			tiles = (tiles_reg == 0) ? 1 : (tiles_reg > MAX_TILES) ? MAX_TILES : tiles_reg;
			height = (height_reg == 0) ? 1 : (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
			row = (rows_cnt >= height) ? height - 1 : rows_cnt;
			col = (col_cnt >= tiles) ? tiles - 1 : col_cnt;
			cur = top_first ? row : height - 1 - row;
			last_col = (col == tiles - 1);
			last_row = (row == height - 1);
			w.pixels = shift_row;
			w.pair = PAIR_W'((cur % TILE_EDGE) + (cur / TILE_EDGE) * tiles * TILE_EDGE
				+ col * TILE_EDGE);
			w.last = last_col && last_row;
			pending.push_back(w);
			if (last_col) begin
				col_cnt = 0;
				if (last_row) begin
					clear_image();
					return 1;
				end
				rows_cnt = row + 1;
			end else begin
				col_cnt = col + 1;
			end
			return 0;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b);
			logic [BYTE_W-1:0] hdr;
			int unsigned n;
			if (!rle_on) begin
				void'(add_pixel(b));
				return;
			end
			if (want_value) begin
				hdr = pkt_count;
				want_value = 0;
				if (hdr[HDR_RUN_BIT]) begin
					n = hdr[HDR_CNT_W-1:0] + 1;
					pkt_count = 0;
					for (int i = 0; i < n; i++) begin
						if (add_pixel(b)) break;
					end
				end else begin
					pkt_count = {1'b0, hdr[HDR_CNT_W-1:0]};
					void'(add_pixel(b));
				end
			end else if (pkt_count != 0) begin
				pkt_count--;
				void'(add_pixel(b));
			end else begin
				pkt_count = b;
				want_value = 1;
			end
		endfunction

		function void check_word(logic [ROW_BITS_W-1:0] pixels, logic [PAIR_W-1:0] pair,
			logic last);
			row_word_t w;
			if (pending.size() == 0) begin
				errors++;
				$error("row word with none expected: row_bits %h pair_index %h", pixels, pair);
				return;
			end
			w = pending.pop_front();
			words_seen++;
			if (w.last) image_ends++;
			if (pixels !== w.pixels) begin
				errors++;
				$error("row_bits expected %h got %h", w.pixels, pixels);
			end
			if (pair !== w.pair) begin
				errors++;
				$error("pair_index expected %0d got %0d", w.pair, pair);
			end
			if (last !== w.last) begin
				errors++;
				$error("last_word expected %b got %b", w.last, last);
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [BYTE_W-1:0]     data_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [ROW_BITS_W-1:0] row_bits;
	logic [PAIR_W-1:0]     pair_index;
	logic                  last_word;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tile_row_board board;
	int burst_left;
	bit steady;
	int hold_len;
	int rx_cycle;
	int cycle_count;
	int n_bytes;
	int n_cfg;
	logic [BYTE_W-1:0] byte_q[$];

	tga_rle_tile_packer #(
		.MAX_TILES_ACROSS(MAX_TILES),
		.MAX_HEIGHT(MAX_ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_bits(row_bits),
		.pair_index(pair_index),
		.last_word(last_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[tga_rle_tile_packer] ERROR");
			$finish;
		end
	end

	// receiver: checks transfers, then picks its ready for the next edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_word(row_bits, pair_index, last_word);
		rx_cycle++;
		if (hold_len > 0) begin
			hold_len--;
			out_ready <= 0;
		end else begin
			case ((rx_cycle / 53) % 4)
				0: out_ready <= 1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic logic [BYTE_W-1:0] pixel_value();
		if ($urandom_range(0, 5) == 0) return BYTE_W'($urandom);
		return BYTE_W'($urandom_range(0, PIX_MAX));
	endfunction

	task automatic send_byte(logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		board.note_byte(b);
		n_bytes++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, data);
		n_cfg++;
	endtask

	task automatic program_regs(bit rle, bit [TILES_W-1:0] tiles, bit [HEIGHT_W-1:0] height,
		bit top);
		write_reg(CFG_RLE_MODE, {10'($urandom), rle});
		write_reg(CFG_TILES_ACROSS, {4'($urandom), tiles});
		write_reg(CFG_IMAGE_HEIGHT, height);
		write_reg(CFG_TOP_DOWN, {10'($urandom), top});
		cfg_valid <= 0;
	endtask

	// waits out every expected word and any run still being expanded
	task automatic settle();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic build_phase(int count);
		int pick, len;
		byte_q.delete();
		while (byte_q.size() < count) begin
			pick = $urandom_range(0, 9);
			if (!board.rle_on) begin
				byte_q.push_back(pixel_value());
			end else if (pick == 0) begin
				byte_q.push_back(BYTE_W'($urandom));
			end else if (pick < 6) begin
				len = ($urandom_range(0, 6) == 0) ? 128 : $urandom_range(1, 24);
				byte_q.push_back(RUN_FLAG | BYTE_W'(len - 1));
				byte_q.push_back(pixel_value());
			end else begin
				len = $urandom_range(1, 10);
				byte_q.push_back(BYTE_W'(len - 1));
				repeat (len) byte_q.push_back(pixel_value());
			end
		end
	endtask

	initial begin
		bit [TILES_W-1:0] tiles_tab[PHASES];
		bit [HEIGHT_W-1:0] height_tab[PHASES];
		bit rle, top;
		tiles_tab = '{1, 0, 64, 127, 2, 1, 3, 65};
		height_tab = '{2, 1, 1024, 0, 1, 2047, 3, 1};
		arst_n = 0;
		in_valid = 0;
		data_byte = 0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = CFG_RLE_MODE;
		cfg_data = 0;
		burst_left = 0;
		steady = 1;
		hold_len = 0;
		board = new();
		board.reset_all();
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// reset defaults: raw pixels, extremes and out-of-range indexes
		byte_q = '{8'd0, 8'd15, 8'd16, 8'd255, 8'd1, 8'd2, 8'd4, 8'd8,
			8'd128, 8'd14, 8'd7, 8'd31, 8'd9, 8'd170, 8'd85, 8'd3};
		foreach (byte_q[i]) send_byte(byte_q[i]);
		settle();

		// one-word image, bottom-up; long run crossing the image end, open raw packet
		program_regs(1, 1, 1, 0);
		byte_q = '{RUN_FLAG | 8'd15, 8'd7, 8'd0, 8'h22, RUN_FLAG | 8'd1, 8'd15,
			RUN_FLAG | 8'd127, 8'hFE, 8'd127, 8'd5, 8'd12};
		foreach (byte_q[i]) send_byte(byte_q[i]);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			rle = (p == 0) ? 1'b0 : (p == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
			top = (p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
			program_regs(rle, tiles_tab[p], height_tab[p], top);
			steady = (p % 3 == 1);
			if (p == 2) hold_len = 600;
			build_phase(PHASE_BYTES);
			foreach (byte_q[i]) send_byte(byte_q[i]);
			settle();
		end

		$display("sent %0d pixel data bytes across %0d register writes", n_bytes, n_cfg);
		$display("checked %0d row words, %0d of them closing an image",
			board.words_seen, board.image_ends);
		if (board.errors == 0)
			$display("[tga_rle_tile_packer] OK");
		else
			$display("[tga_rle_tile_packer] ERROR");
		$finish;
	end

endmodule

/* tga_rle_tile_packer.f */
rtl/core/trtp_pkg.sv
rtl/core/trtp_ctrl.sv
rtl/core/trtp_dp.sv
rtl/core/tga_rle_tile_packer.sv
tb/testbench.sv
